>>> rtl/core/swfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types and constants for the sync word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

    // Default geometry
    localparam int CHANNELS_DEF   = 7;
    localparam int WORD_BYTES_DEF = 4;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 3;
    localparam int CFG_W   = 1;

    // Register indexes
    localparam logic [CFG_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_W-1:0] CFG_SYNC_SECOND = 1'b1;

    // Reset values of the header registers
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;

    typedef enum logic [1:0] {
        H_FIRST  = 2'd0,
        H_SECOND = 2'd1,
        H_DATA   = 2'd2
    } t_hunt_state;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_LOAD = 2'd2,
        ST_EMIT = 2'd3
    } t_seq_state;

    // Control of the shared byte shift unit
    typedef struct packed {
        logic clr;
        logic shift;
    } t_asm_ctl;

endpackage : swfd_pkg
`default_nettype wire

>>> rtl/core/swfd_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_store
// Payload byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swfd_store #(
    parameter int   DEPTH  = swfd_pkg::CHANNELS_DEF * swfd_pkg::WORD_BYTES_DEF,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [swfd_pkg::BYTE_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [swfd_pkg::BYTE_W-1:0] o_rd_data
);

    logic [swfd_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [swfd_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : swfd_store
`default_nettype wire

>>> rtl/core/swfd_asm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_asm
// Shared byte shift unit: builds a channel word one byte per step.
// ----------------------------------------------------------------------------
module swfd_asm (
    input  wire logic                        i_clk,
    input  wire swfd_pkg::t_asm_ctl          i_ctl,
    input  wire logic [swfd_pkg::BYTE_W-1:0] i_byte,
    output logic      [swfd_pkg::WORD_W-1:0] o_word
);

    logic [swfd_pkg::WORD_W-1:0] r_word;

    // Bytes arrive highest first, so the first payload byte ends up least
    // significant and unused upper bytes stay zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_word <= '0;
        end else if (i_ctl.shift) begin
            r_word <= {r_word[swfd_pkg::WORD_W-swfd_pkg::BYTE_W-1:0], i_byte};
        end
    end

    assign o_word = r_word;

endmodule : swfd_asm
`default_nettype wire

>>> rtl/core/swfd_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_seq
// Header hunt, payload capture and per-channel read-out sequencer.
// ----------------------------------------------------------------------------
module swfd_seq #(
    parameter int  CHANNELS    = swfd_pkg::CHANNELS_DEF,
    parameter int  WORD_BYTES  = swfd_pkg::WORD_BYTES_DEF,
    localparam int FRAME_BYTES = CHANNELS * WORD_BYTES,
    localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [swfd_pkg::CFG_W-1:0]  i_cfg_index,
    input  wire logic [swfd_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    input  wire logic [swfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_wr_en,
    output logic      [ADDR_W-1:0]           o_wr_addr,
    output logic                             o_rd_en,
    output logic      [ADDR_W-1:0]           o_rd_addr,
    output swfd_pkg::t_asm_ctl               o_asm_ctl,
    output logic      [CH_W-1:0]             o_channel,
    output logic                             o_last
);

    localparam int USED_BYTES = (WORD_BYTES < 4) ? WORD_BYTES : 4;
    localparam int POS_W      = (USED_BYTES > 1) ? $clog2(USED_BYTES) : 1;

    swfd_pkg::t_seq_state  r_state, n_state;
    swfd_pkg::t_hunt_state r_hunt, n_hunt;

    logic [swfd_pkg::BYTE_W-1:0] r_sync_first;
    logic [swfd_pkg::BYTE_W-1:0] r_sync_second;

    logic [ADDR_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0] r_base,  n_base;
    logic [ADDR_W-1:0] r_addr,  n_addr;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [CH_W-1:0]   r_ch,    n_ch;

    logic in_acc;
    logic out_acc;
    logic frame_done;
    logic ch_last;

    assign in_acc     = i_in_valid && (r_state == swfd_pkg::ST_IDLE);
    assign out_acc    = (r_state == swfd_pkg::ST_EMIT) && !i_out_stall;
    assign frame_done = in_acc && (r_hunt == swfd_pkg::H_DATA)
                        && (r_count == ADDR_W'(FRAME_BYTES - 1));
    assign ch_last    = (r_ch == CH_W'(CHANNELS - 1));

    // header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= swfd_pkg::SYNC_FIRST_RST;
            r_sync_second <= swfd_pkg::SYNC_SECOND_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                swfd_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                swfd_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swfd_pkg::ST_IDLE: if (frame_done) n_state = swfd_pkg::ST_READ;
            swfd_pkg::ST_READ: n_state = swfd_pkg::ST_LOAD;
            swfd_pkg::ST_LOAD: begin
                n_state = (r_pos == '0) ? swfd_pkg::ST_EMIT : swfd_pkg::ST_READ;
            end
            swfd_pkg::ST_EMIT: begin
                if (out_acc) begin
                    n_state = ch_last ? swfd_pkg::ST_IDLE : swfd_pkg::ST_READ;
                end
            end
            default: n_state = swfd_pkg::ST_IDLE;
        endcase
    end

    // hunt and counters
    always_comb begin
        n_hunt  = r_hunt;
        n_count = r_count;
        n_base  = r_base;
        n_addr  = r_addr;
        n_pos   = r_pos;
        n_ch    = r_ch;
        if (in_acc) begin
            case (r_hunt)
                swfd_pkg::H_SECOND: begin
                    if (i_rx_byte == r_sync_second) begin
                        n_hunt  = swfd_pkg::H_DATA;
                        n_count = '0;
                    end else if (i_rx_byte == r_sync_first) begin
                        n_hunt = swfd_pkg::H_SECOND;
                    end else begin
                        n_hunt = swfd_pkg::H_FIRST;
                    end
                end
                swfd_pkg::H_DATA: begin
                    if (frame_done) begin
                        n_hunt  = swfd_pkg::H_FIRST;
                        n_count = '0;
                        n_ch    = '0;
                        n_base  = '0;
                        n_addr  = ADDR_W'(USED_BYTES - 1);
                        n_pos   = POS_W'(USED_BYTES - 1);
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    n_hunt = (i_rx_byte == r_sync_first) ? swfd_pkg::H_SECOND
                                                         : swfd_pkg::H_FIRST;
                end
            endcase
        end
        if ((r_state == swfd_pkg::ST_LOAD) && (r_pos != '0)) begin
            n_pos  = r_pos - 1'b1;
            n_addr = r_addr - 1'b1;
        end
        if (out_acc && !ch_last) begin
            n_ch   = r_ch + 1'b1;
            n_base = r_base + ADDR_W'(WORD_BYTES);
            n_addr = r_base + ADDR_W'(WORD_BYTES) + ADDR_W'(USED_BYTES - 1);
            n_pos  = POS_W'(USED_BYTES - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swfd_pkg::ST_IDLE;
            r_hunt  <= swfd_pkg::H_FIRST;
            r_count <= '0;
            r_base  <= '0;
            r_addr  <= '0;
            r_pos   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_hunt  <= n_hunt;
            r_count <= n_count;
            r_base  <= n_base;
            r_addr  <= n_addr;
            r_pos   <= n_pos;
            r_ch    <= n_ch;
        end
    end

    // outputs
    always_comb begin
        o_in_stall      = (r_state != swfd_pkg::ST_IDLE);
        o_out_valid     = (r_state == swfd_pkg::ST_EMIT);
        o_wr_en         = in_acc && (r_hunt == swfd_pkg::H_DATA);
        o_wr_addr       = r_count;
        o_rd_en         = (r_state == swfd_pkg::ST_READ);
        o_rd_addr       = r_addr;
        o_asm_ctl.clr   = (r_state == swfd_pkg::ST_IDLE) || out_acc;
        o_asm_ctl.shift = (r_state == swfd_pkg::ST_LOAD);
        o_channel       = r_ch;
        o_last          = ch_last;
    end

endmodule : swfd_seq
`default_nettype wire

>>> rtl/core/sync_word_frame_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_top
// Two-byte sync header deframer: hunts for the header, stores one frame of
// payload bytes and reads it back out as one word per channel.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_stall  i_rx_byte
//  out      source     o_out_valid / i_out_stall
//                                               o_channel_index, o_channel_word,
//                                               o_frame_last
//  cfg      sink       i_cfg_wr_en             i_cfg_index, i_cfg_data
//
//  A header or non-final payload byte does not stall the input; the block is
//  ready again in the next cycle.
//  After the final payload byte the input stalls while the frame is read out:
//  per channel, each of its min(WORD_BYTES, 4) bytes is fetched through the
//  single memory read port and shifted into the shift unit, then the request
//  is held until taken.
//  Reset is synchronous, active low; the payload memory is not cleared.
//  A stalled output request holds its payload until taken.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_top #(
    parameter int CHANNELS   = swfd_pkg::CHANNELS_DEF,
    parameter int WORD_BYTES = swfd_pkg::WORD_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [swfd_pkg::CFG_W-1:0]   i_cfg_index,
    input  wire logic [swfd_pkg::BYTE_W-1:0]  i_cfg_data,
    // byte input
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [swfd_pkg::BYTE_W-1:0]  i_rx_byte,
    // word output
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [swfd_pkg::INDEX_W-1:0] o_channel_index,
    output logic      [swfd_pkg::WORD_W-1:0]  o_channel_word,
    output logic                              o_frame_last
);

    localparam int FRAME_BYTES = CHANNELS * WORD_BYTES;
    localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [swfd_pkg::BYTE_W-1:0] rd_data;
    swfd_pkg::t_asm_ctl          asm_ctl;
    logic [CH_W-1:0]             channel;
    logic [CH_W+swfd_pkg::INDEX_W-1:0] channel_ext;

    // sequencer: header hunt, capture counter, read-out control
    swfd_seq #(
        .CHANNELS   (CHANNELS),
        .WORD_BYTES (WORD_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_asm_ctl   (asm_ctl),
        .o_channel   (channel),
        .o_last      (o_frame_last)
    );

    // frame payload, written in arrival order
    swfd_store #(
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // word builder, one byte per load step
    swfd_asm u_asm (
        .i_clk  (i_clk),
        .i_ctl  (asm_ctl),
        .i_byte (rd_data),
        .o_word (o_channel_word)
    );

    // channel index is the low three bits of the channel counter
    assign channel_ext     = {{swfd_pkg::INDEX_W{1'b0}}, channel};
    assign o_channel_index = channel_ext[swfd_pkg::INDEX_W-1:0];

endmodule : sync_word_frame_deframer_top
`default_nettype wire

>>> rtl/core/swfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module swfd_checker #(
    parameter int CHANNELS = swfd_pkg::CHANNELS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [swfd_pkg::INDEX_W-1:0] o_channel_index,
    input wire logic [swfd_pkg::WORD_W-1:0]  o_channel_word,
    input wire logic                         o_frame_last
);

    localparam logic [swfd_pkg::INDEX_W-1:0] LAST_IDX =
        swfd_pkg::INDEX_W'(CHANNELS - 1);

    // a waiting request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_channel_word)
            && $stable(o_channel_index) && $stable(o_frame_last))
        else $error("output request changed while stalled");

    // input is never taken while a word is being presented
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input ready during read-out");

    // the last flag marks the final channel only
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_channel_index == LAST_IDX)
        else $error("last flag on wrong channel");

    // after the final word the block is ready for bytes again
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_frame_last |=> !o_out_valid && !o_in_stall)
        else $error("no return to hunting after frame");

    // after a non-final word the input stays stalled while the next channel is loaded
    a_ch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_frame_last |=> !o_out_valid && o_in_stall)
        else $error("read-out sequence broken");

endmodule : swfd_checker

bind sync_word_frame_deframer_top swfd_checker #(
    .CHANNELS (CHANNELS)
) u_swfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_channel_index (o_channel_index),
    .o_channel_word  (o_channel_word),
    .o_frame_last    (o_frame_last)
);
`default_nettype wire
